// ===== hw/rtl/lcdw_pkg.sv =====
// lcdw_pkg: types, codes and character rom tables for the lcd write generator
// no dependencies
`default_nettype none

package lcdw_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] char_byte;
    logic [4:0] cursor_pos;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
  } out_item_t;

  typedef enum logic {
    OP_PUT    = 1'b0,
    OP_CURSOR = 1'b1
  } op_e;

  // lead byte tracking, one-hot
  typedef enum logic [2:0] {
    PFX_NONE = 3'b001,
    PFX_D0   = 3'b010,
    PFX_D1   = 3'b100
  } prefix_e;

  // classified work for the back end
  typedef enum logic [1:0] {
    K_CMD    = 2'd0,
    K_DATA   = 2'd1,
    K_MAP_D0 = 2'd2,
    K_MAP_D1 = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } cmd_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] LEAD_D0   = 8'hd0;
  localparam logic [7:0] LEAD_D1   = 8'hd1;

  localparam logic [7:0] CMD_LINE1 = 8'h80;
  localparam logic [7:0] CMD_LINE2 = 8'hc0;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_DDRAM = 8'h80;

  localparam logic [4:0] LINE1_LAST = 5'd15;
  localparam logic [6:0] LINE2_OFS  = 7'd48;

  localparam logic [7:0] D0_LO     = 8'h90;
  localparam logic [7:0] D0_HI     = 8'hbf;
  localparam logic [7:0] D0_IO     = 8'h81;
  localparam logic [7:0] D0_IO_MAP = 8'ha2;
  localparam logic [7:0] D1_LO     = 8'h80;
  localparam logic [7:0] D1_HI     = 8'h8f;
  localparam logic [7:0] D1_YO     = 8'h91;
  localparam logic [7:0] D1_YO_MAP = 8'hb5;

  localparam int D0_DEPTH = 48;
  localparam int D1_DEPTH = 16;

  localparam logic [7:0] MAP_D0 [D0_DEPTH] = '{
    8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
    8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
    8'hac, 8'he2, 8'had, 8'hae, 8'hc4, 8'haf, 8'hb0, 8'hb1,
    8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
    8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe
  };

  localparam logic [7:0] MAP_D1 [D1_DEPTH] = '{
    8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
    8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7
  };

endpackage

`default_nettype wire

// ===== hw/rtl/lcdw_front.sv =====
// lcdw_front: accepts items, tracks the utf-8 lead byte and classifies work
// depends on lcdw_pkg
`default_nettype none

module lcdw_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    accept_i,
  input  lcdw_pkg::in_item_t     item_i,
  output logic                   cmd_valid_o,
  output lcdw_pkg::cmd_t         cmd_o
);
  import lcdw_pkg::*;

  prefix_e    prefix_q, prefix_d;
  logic [6:0] pos_adj;
  logic [7:0] b;

  assign b = item_i.char_byte;

  always_comb begin
    pos_adj = {2'b00, item_i.cursor_pos};
    if (item_i.cursor_pos > LINE1_LAST) begin
      pos_adj = {2'b00, item_i.cursor_pos} + LINE2_OFS;
    end
  end

  always_comb begin
    prefix_d    = prefix_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = K_DATA;
    cmd_o.value = b;
    if (item_i.op == OP_CURSOR) begin
      cmd_valid_o = accept_i;
      cmd_o.kind  = K_CMD;
      cmd_o.value = CMD_DDRAM | {1'b0, pos_adj};
    end else begin
      case (prefix_q)
        PFX_D0: begin
          cmd_valid_o = accept_i;
          cmd_o.kind  = K_MAP_D0;
          if (accept_i) prefix_d = PFX_NONE;
        end
        PFX_D1: begin
          cmd_valid_o = accept_i;
          cmd_o.kind  = K_MAP_D1;
          if (accept_i) prefix_d = PFX_NONE;
        end
        default: begin
          cmd_valid_o = accept_i;
          if (accept_i) prefix_d = PFX_NONE;
          if (b == CH_CR) begin
            cmd_o.kind  = K_CMD;
            cmd_o.value = CMD_LINE1;
          end else if (b == CH_LF) begin
            cmd_o.kind  = K_CMD;
            cmd_o.value = CMD_LINE2;
          end else if (b == CH_TAB) begin
            cmd_o.kind  = K_CMD;
            cmd_o.value = CMD_CLEAR;
          end else if (b == LEAD_D0) begin
            cmd_valid_o = 1'b0;
            if (accept_i) prefix_d = PFX_D0;
          end else if (b == LEAD_D1) begin
            cmd_valid_o = 1'b0;
            if (accept_i) prefix_d = PFX_D1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= PFX_NONE;
    end else begin
      prefix_q <= prefix_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdw_cmdq.sv =====
// lcdw_cmdq: two-entry queue of classified work between front and back
// depends on lcdw_pkg
`default_nettype none

module lcdw_cmdq (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  lcdw_pkg::cmd_t     data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire                pop_i,
  output lcdw_pkg::cmd_t     data_o
);
  import lcdw_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdw_back.sv =====
// lcdw_back: maps classified work to bus writes and holds them in the result queue
// depends on lcdw_pkg
`default_nettype none

module lcdw_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cmd_valid_i,
  input  lcdw_pkg::cmd_t        cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  wire                   pop_i,
  output lcdw_pkg::out_item_t   item_o
);
  import lcdw_pkg::*;

  out_item_t  mem_q [2];
  out_item_t  res;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       full, do_pop;
  logic [7:0] v;
  logic [7:0] d0_off;

  assign v      = cmd_i.value;
  assign d0_off = v - D0_LO;

  always_comb begin
    res.is_data  = 1'b1;
    res.bus_byte = v;
    case (cmd_i.kind)
      K_CMD: begin
        res.is_data = 1'b0;
      end
      K_MAP_D0: begin
        if (v >= D0_LO && v <= D0_HI) res.bus_byte = MAP_D0[d0_off[5:0]];
        else if (v == D0_IO)          res.bus_byte = D0_IO_MAP;
      end
      K_MAP_D1: begin
        if (v >= D1_LO && v <= D1_HI) res.bus_byte = MAP_D1[v[3:0]];
        else if (v == D1_YO)          res.bus_byte = D1_YO_MAP;
      end
      default: begin
        res.is_data = 1'b1;
      end
    endcase
  end

  assign full      = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign item_o    = mem_q[rd_q];
  assign cmd_pop_o = cmd_valid_i && !full;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_pop_o && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!cmd_pop_o && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) mem_q[wr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_pop_o) wr_q <= !wr_q;
      if (do_pop)    rd_q <= !rd_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_char_stream_to_bus_writes_core.sv =====
// lcd_char_stream_to_bus_writes_core: top level of the character lcd write generator
// depends on lcdw_pkg, lcdw_front, lcdw_cmdq, lcdw_back
`default_nettype none

// Turns a character byte stream and cursor moves into display bus writes
// (register select plus byte). One item is taken every cycle while full is
// low. The edge that takes an item writes its work into the classify queue;
// from there it is written into the two-entry result queue, whose head is on
// the result ports for pop to take.
// UTF-8 lead bytes 0xD0 and 0xD1 give no result; the byte after one is mapped
// into the display character rom. full rises only when both queues back up
// because pop stays low.
module lcd_char_stream_to_bus_writes_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push,
  output logic                  full,
  input  lcdw_pkg::in_item_t    in_item_i,
  output logic                  empty,
  input  wire                   pop,
  output lcdw_pkg::out_item_t   out_item_o
);
  import lcdw_pkg::*;

  logic accept;
  logic cq_push, cq_full, cq_valid, cq_pop;
  cmd_t cq_in, cq_out;

  assign accept = push && !full;
  assign full   = cq_full;

  lcdw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cmd_valid_o (cq_push),
    .cmd_o       (cq_in)
  );

  lcdw_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_in),
    .full_o  (cq_full),
    .valid_o (cq_valid),
    .pop_i   (cq_pop),
    .data_o  (cq_out)
  );

  lcdw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cq_valid),
    .cmd_i       (cq_out),
    .cmd_pop_o   (cq_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

  // a cursor move always produces work
  a_cursor_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.op == OP_CURSOR) |-> cq_push)
    else $error("cursor item dropped");

  // results never appear without queued work
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !cq_valid) |=> empty)
    else $error("result appeared from nothing");

  // back end only drains a non-empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop |-> cq_valid)
    else $error("queue drained while empty");

endmodule

`default_nettype wire
